// File: hdl/ultrasonic_ranger_controller_assert.svh
// Assertion macros for the ultrasonic ranger controller.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ULTRASONIC_RANGER_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_RANGER_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define USR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("usr assertion failed");

// next-cycle implication
`define USR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("usr assertion failed");

`else

`define USR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define USR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/usr_pkg.sv
// Shared types and constants for the ultrasonic ranger controller.
// No dependencies; imported by usr_core and the top level.
package usr_pkg;

  localparam int PERIOD_W  = 20;
  localparam int TRIGGER_W = 10;
  localparam int ECHO_W    = 16;
  localparam int DIST_W    = 11;
  localparam int CFG_W     = 20;

  typedef enum logic [0:0] {
    CFG_PERIOD  = 1'b0,
    CFG_TRIGGER = 1'b1
  } cfg_idx_t;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 20'd100000;
  localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = 10'd10;
  localparam logic [ECHO_W-1:0]    ECHO_MAX      = 16'hFFFF;
  localparam logic [DIST_W-1:0]    DIST_MAX      = 11'd1129;

  // x / 58 for 16-bit x: (x * 72316) >> 22, exact over the whole range
  localparam int DIV_SHIFT = 22;
  localparam int DIV_MUL_W = 17;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd72316;
  localparam int PROD_W = ECHO_W + DIV_MUL_W;

  typedef struct packed {
    logic              trigger_out;
    logic [DIST_W-1:0] distance_cm;
    logic              distance_new;
    logic              period_pulse;
  } res_t;

endpackage

// File: hdl/ultrasonic_ranger_controller.sv
// Ultrasonic echo ranging controller, one input beat per timer tick.
// Depends on usr_pkg, usr_core and ultrasonic_ranger_controller_assert.svh.
//
// Usage: send one input beat per microsecond tick carrying the sampled echo
// pin level (in_echo_level). Every input beat produces exactly one output
// beat: trigger pin level, last distance in cm, a new-distance flag and the
// period pulse. Timer and echo state advance only on accepted beats.
// Configuration (period_ticks index 0, trigger_ticks index 1) is written
// through cfg_we/cfg_index/cfg_data while no beats are in flight; the user
// must ensure this, the block does not enforce it. Each result is registered
// in the output register, or in the skid entry if a stall holds that one.
// Throughput: one beat per cycle while out_stall is low (single update stage).
// Output side: an output register plus one skid entry. When the receiver
// stalls, one more input beat is still taken into the skid entry; in_stall
// rises only while that entry is full.
// Reset (rst_n low, synchronous): all counters and the stored distance
// clear, configuration returns to 100000 and 10 ticks, both buffers empty.

`include "ultrasonic_ranger_controller_assert.svh"

module ultrasonic_ranger_controller import usr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_echo_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_trigger_out,
  output logic [DIST_W-1:0] out_distance_cm,
  output logic              out_distance_new,
  output logic              out_period_pulse
);

  res_t res;
  res_t out_r;
  res_t skid_r;
  logic out_vld_r;
  logic skid_vld_r;
  logic in_take;
  logic out_take;

  assign in_stall = skid_vld_r;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;

  usr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_idx_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .step       (in_take),
    .echo_level (in_echo_level),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  // payload: skid drains into the output register, new beat lands where free
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_take) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_trigger_out  = out_r.trigger_out;
  assign out_distance_cm  = out_r.distance_cm;
  assign out_distance_new = out_r.distance_new;
  assign out_period_pulse = out_r.period_pulse;

  `USR_ASSERT_IMPL(a_skid_has_out, clk, rst_n, skid_vld_r, out_vld_r)
  `USR_ASSERT_NEXT(a_skid_fill, clk, rst_n, in_take && out_vld_r && out_stall, skid_vld_r)
  `USR_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_vld_r && out_take, out_vld_r && !skid_vld_r)

endmodule

// File: hdl/usr_core.sv
// Ranging state: period/trigger timer, echo width counter and distance store.
// Depends on usr_pkg and ultrasonic_ranger_controller_assert.svh.
`include "ultrasonic_ranger_controller_assert.svh"

module usr_core import usr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             step,
  input  logic             echo_level,
  output res_t             res
);

  logic [PERIOD_W-1:0]  period_ticks_r;
  logic [TRIGGER_W-1:0] trigger_ticks_r;

  logic                 trig_phase_r, trig_phase_nxt;
  logic [PERIOD_W-1:0]  period_count_r, period_count_nxt;
  logic                 parity_r, parity_nxt;
  logic [TRIGGER_W-1:0] trigger_count_r, trigger_count_nxt;
  logic [ECHO_W-1:0]    echo_width_r, echo_width_nxt;
  logic                 echo_prev_r;
  logic [DIST_W-1:0]    dist_r, dist_nxt;

  logic [PERIOD_W:0]    period_inc;
  logic [TRIGGER_W:0]   trigger_inc;
  logic [PROD_W-1:0]    prod;
  logic                 pulse;
  logic                 fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r  <= PERIOD_RESET;
      trigger_ticks_r <= TRIGGER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD:  period_ticks_r  <= cfg_data[PERIOD_W-1:0];
        CFG_TRIGGER: trigger_ticks_r <= cfg_data[TRIGGER_W-1:0];
        default: ;
      endcase
    end
  end

  assign period_inc  = {1'b0, period_count_r} + 1'b1;
  assign trigger_inc = {1'b0, trigger_count_r} + 1'b1;

  // timer: period counting paused while trigger is high
  always_comb begin
    trig_phase_nxt    = trig_phase_r;
    period_count_nxt  = period_count_r;
    parity_nxt        = parity_r;
    trigger_count_nxt = trigger_count_r;
    pulse             = 1'b0;
    if (trig_phase_r) begin
      if (trigger_inc >= {1'b0, trigger_ticks_r}) begin
        trig_phase_nxt    = 1'b0;
        trigger_count_nxt = '0;
        period_count_nxt  = '0;
      end else begin
        trigger_count_nxt = trigger_inc[TRIGGER_W-1:0];
      end
    end else if (period_inc >= {1'b0, period_ticks_r}) begin
      pulse            = 1'b1;
      period_count_nxt = '0;
      if (parity_r) begin
        parity_nxt        = 1'b0;
        trig_phase_nxt    = 1'b1;
        trigger_count_nxt = '0;
      end else begin
        parity_nxt = 1'b1;
      end
    end else begin
      period_count_nxt = period_inc[PERIOD_W-1:0];
    end
  end

  assign prod = PROD_W'(echo_width_r) * PROD_W'(DIV_MUL);

  always_comb begin
    echo_width_nxt = echo_width_r;
    dist_nxt       = dist_r;
    fresh          = 1'b0;
    if (echo_level && !echo_prev_r) begin
      echo_width_nxt = ECHO_W'(1);
    end else if (echo_level) begin
      if (echo_width_r != ECHO_MAX) begin
        echo_width_nxt = echo_width_r + 1'b1;
      end
    end else if (echo_prev_r) begin
      dist_nxt = prod[DIV_SHIFT +: DIST_W];
      fresh    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_phase_r    <= 1'b0;
      period_count_r  <= '0;
      parity_r        <= 1'b0;
      trigger_count_r <= '0;
      echo_width_r    <= '0;
      echo_prev_r     <= 1'b0;
      dist_r          <= '0;
    end else if (step) begin
      trig_phase_r    <= trig_phase_nxt;
      period_count_r  <= period_count_nxt;
      parity_r        <= parity_nxt;
      trigger_count_r <= trigger_count_nxt;
      echo_width_r    <= echo_width_nxt;
      echo_prev_r     <= echo_level;
      dist_r          <= dist_nxt;
    end
  end

  assign res.trigger_out  = trig_phase_nxt;
  assign res.distance_cm  = dist_nxt;
  assign res.distance_new = fresh;
  assign res.period_pulse = pulse;

  `USR_ASSERT_IMPL(a_trig_period_clear, clk, rst_n, trig_phase_r, period_count_r == '0)
  `USR_ASSERT_IMPL(a_idle_trig_count, clk, rst_n, !trig_phase_r, trigger_count_r == '0)
  `USR_ASSERT_IMPL(a_dist_range, clk, rst_n, 1'b1, dist_r <= DIST_MAX)

endmodule
